[hw/rtl/css_pkg.sv]
package css_pkg;

   localparam int MAX_TERMS   = 64;

   localparam int ID_W        = 20;
   localparam int WEIGHT_W    = 16;
   localparam int PROD_W      = 2 * WEIGHT_W;
   localparam int SUM_W       = 39;
   localparam int CNT_W       = $clog2(MAX_TERMS + 1);

   localparam int FRAC_W      = 16;
   localparam int SIM_W       = FRAC_W + 1;
   localparam int NORM_SHIFT  = 24;
   localparam int RAD_W       = 64;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int SQ_REM_W    = ROOT_W + 2;
   localparam int DEN_W       = 2 * ROOT_W;
   localparam int SQRT_STEPS  = RAD_W / 2;
   localparam int DIV_STEPS   = FRAC_W;
   localparam int STEP_W      = $clog2(SQRT_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SIM_W-1:0] SIM_ONE = {1'b1, {FRAC_W{1'b0}}};

   typedef struct packed {
      logic [ID_W-1:0]  doc_id;
      logic [SUM_W-1:0] dot_sum;
      logic [SUM_W-1:0] query_sum;
      logic [SUM_W-1:0] doc_sum;
      logic             overflow;
   } css_job_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0]   root;
   } css_root_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SQRT,
      B_MUL,
      B_CHECK,
      B_DIV,
      B_DONE
   } css_back_state_type;

   // One digit of a restoring square root: bring down the next bit pair.
   function automatic css_root_type sqrt_step(css_root_type cur, logic [1:0] pair);
      logic [SQ_REM_W+1:0] shifted;
      logic [SQ_REM_W+1:0] trial;
      css_root_type        nxt;
      shifted = {cur.rem, pair};
      trial   = {2'b00, cur.root, 2'b01};
      if (shifted >= trial) begin
         nxt.rem  = SQ_REM_W'(shifted - trial);
         nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
         nxt.rem  = SQ_REM_W'(shifted);
         nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

[hw/rtl/css_front.sv]
module css_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [css_pkg::ID_W-1:0]         req_doc_id,
   input  logic [css_pkg::WEIGHT_W-1:0]     req_query_weight,
   input  logic [css_pkg::WEIGHT_W-1:0]     req_doc_weight,
   input  logic                             req_last_term,
   input  logic                             q_full,
   output logic                             push_valid,
   output css_pkg::css_job_type             push_job
);

   logic                           p_valid_ff, p_valid_in;
   logic                           p_last_ff, p_last_in;
   logic [css_pkg::ID_W-1:0]       p_id_ff, p_id_in;
   logic [css_pkg::PROD_W-1:0]     p_dot_ff, p_dot_in;
   logic [css_pkg::PROD_W-1:0]     p_qq_ff, p_qq_in;
   logic [css_pkg::PROD_W-1:0]     p_dd_ff, p_dd_in;

   logic [css_pkg::SUM_W-1:0]      dot_ff, dot_in;
   logic [css_pkg::SUM_W-1:0]      qsum_ff, qsum_in;
   logic [css_pkg::SUM_W-1:0]      dsum_ff, dsum_in;
   logic [css_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                           ovf_ff, ovf_in;

   logic                           advance;
   logic                           take;
   logic [css_pkg::SUM_W-1:0]      dot_acc, qsum_acc, dsum_acc;
   logic                           ovf_acc;

   // The product stage only stalls when it holds a last term and the queue is full.
   assign advance   = !p_valid_ff || !p_last_ff || !q_full;
   assign req_ready = advance;
   assign take      = cnt_ff < css_pkg::CNT_W'(css_pkg::MAX_TERMS);

   always_comb begin
      dot_acc  = take ? dot_ff + css_pkg::SUM_W'(p_dot_ff) : dot_ff;
      qsum_acc = take ? qsum_ff + css_pkg::SUM_W'(p_qq_ff) : qsum_ff;
      dsum_acc = take ? dsum_ff + css_pkg::SUM_W'(p_dd_ff) : dsum_ff;
      ovf_acc  = ovf_ff | !take;
   end

   always_comb begin
      p_valid_in = p_valid_ff;
      p_last_in  = p_last_ff;
      p_id_in    = p_id_ff;
      p_dot_in   = p_dot_ff;
      p_qq_in    = p_qq_ff;
      p_dd_in    = p_dd_ff;
      if (advance) begin
         p_valid_in = req_valid;
         p_last_in  = req_last_term;
         p_id_in    = req_doc_id;
         p_dot_in   = css_pkg::PROD_W'(req_query_weight) * css_pkg::PROD_W'(req_doc_weight);
         p_qq_in    = css_pkg::PROD_W'(req_query_weight) * css_pkg::PROD_W'(req_query_weight);
         p_dd_in    = css_pkg::PROD_W'(req_doc_weight) * css_pkg::PROD_W'(req_doc_weight);
      end
   end

   always_comb begin
      dot_in  = dot_ff;
      qsum_in = qsum_ff;
      dsum_in = dsum_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      if (p_valid_ff && advance) begin
         if (p_last_ff) begin
            // close the run: the sums travel in the queue word
            dot_in  = '0;
            qsum_in = '0;
            dsum_in = '0;
            cnt_in  = '0;
            ovf_in  = 1'b0;
         end else begin
            dot_in  = dot_acc;
            qsum_in = qsum_acc;
            dsum_in = dsum_acc;
            cnt_in  = take ? css_pkg::CNT_W'(cnt_ff + 1'b1) : cnt_ff;
            ovf_in  = ovf_acc;
         end
      end
   end

   assign push_valid         = p_valid_ff && p_last_ff && advance;
   assign push_job.doc_id    = p_id_ff;
   assign push_job.dot_sum   = dot_acc;
   assign push_job.query_sum = qsum_acc;
   assign push_job.doc_sum   = dsum_acc;
   assign push_job.overflow  = ovf_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         dot_ff     <= '0;
         qsum_ff    <= '0;
         dsum_ff    <= '0;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
         dot_ff     <= dot_in;
         qsum_ff    <= qsum_in;
         dsum_ff    <= dsum_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      p_last_ff <= p_last_in;
      p_id_ff   <= p_id_in;
      p_dot_ff  <= p_dot_in;
      p_qq_ff   <= p_qq_in;
      p_dd_ff   <= p_dd_in;
   end

endmodule

[hw/rtl/css_queue.sv]
module css_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  css_pkg::css_job_type  push_job,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output css_pkg::css_job_type  pop_job
);

   css_pkg::css_job_type          mem_ff [css_pkg::QUEUE_DEPTH];
   logic [css_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [css_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [css_pkg::QCNT_W-1:0]    cnt_ff, cnt_in;

   assign full    = cnt_ff == css_pkg::QCNT_W'(css_pkg::QUEUE_DEPTH);
   assign empty   = cnt_ff == '0;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_valid ? css_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? css_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      case ({push_valid, pop})
         2'b10:   cnt_in = css_pkg::QCNT_W'(cnt_ff + 1'b1);
         2'b01:   cnt_in = css_pkg::QCNT_W'(cnt_ff - 1'b1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("queue word pushed while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue word popped while empty");

endmodule

[hw/rtl/css_back.sv]
module css_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  css_pkg::css_job_type          q_job,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [css_pkg::ID_W-1:0]      rsp_score_doc_id,
   output logic [css_pkg::SIM_W-1:0]     rsp_similarity,
   output logic                          rsp_zero_norm,
   output logic                          rsp_term_overflow
);

   css_pkg::css_back_state_type      state_ff, state_in;
   logic [css_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [css_pkg::RAD_W-1:0]        rad_q_ff, rad_q_in;
   logic [css_pkg::RAD_W-1:0]        rad_d_ff, rad_d_in;
   css_pkg::css_root_type            sq_q_ff, sq_q_in;
   css_pkg::css_root_type            sq_d_ff, sq_d_in;
   logic [css_pkg::SUM_W-1:0]        dot_ff, dot_in;
   logic [css_pkg::DEN_W-1:0]        den_ff, den_in;
   logic [css_pkg::DEN_W-1:0]        rem_ff, rem_in;
   logic [css_pkg::FRAC_W-1:0]       quo_ff, quo_in;
   logic [css_pkg::SIM_W-1:0]        sim_ff, sim_in;
   logic [css_pkg::ID_W-1:0]         id_ff, id_in;
   logic                             ovf_ff, ovf_in;
   logic                             zero_ff, zero_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [css_pkg::ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic [css_pkg::SIM_W-1:0]        rsp_sim_ff, rsp_sim_in;
   logic                             rsp_zero_ff, rsp_zero_in;
   logic                             rsp_ovf_ff, rsp_ovf_in;

   logic                             sqrt_last, div_last, saturate;
   logic                             out_free, out_load;
   logic [css_pkg::DEN_W:0]          rem_shift;
   logic                             rem_ge;
   logic [css_pkg::FRAC_W-1:0]       quo_next;

   assign sqrt_last = step_ff == css_pkg::STEP_W'(css_pkg::SQRT_STEPS - 1);
   assign div_last  = step_ff == css_pkg::STEP_W'(css_pkg::DIV_STEPS - 1);
   assign saturate  = rem_ff >= den_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};
   assign quo_next  = {quo_ff[css_pkg::FRAC_W-2:0], rem_ge};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         css_pkg::B_IDLE:  if (!q_empty) state_in = css_pkg::B_SQRT;
         css_pkg::B_SQRT:  if (sqrt_last) state_in = css_pkg::B_MUL;
         css_pkg::B_MUL:   state_in = css_pkg::B_CHECK;
         css_pkg::B_CHECK: begin
            if (zero_ff || saturate) begin
               state_in = css_pkg::B_DONE;
            end else begin
               state_in = css_pkg::B_DIV;
            end
         end
         css_pkg::B_DIV:   if (div_last) state_in = css_pkg::B_DONE;
         css_pkg::B_DONE:  if (out_free) state_in = css_pkg::B_IDLE;
         default:          state_in = css_pkg::B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop    = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         css_pkg::B_IDLE: q_pop    = !q_empty;
         css_pkg::B_DONE: out_load = out_free;
         default: begin
            q_pop    = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in  = step_ff;
      rad_q_in = rad_q_ff;
      rad_d_in = rad_d_ff;
      sq_q_in  = sq_q_ff;
      sq_d_in  = sq_d_ff;
      dot_in   = dot_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      sim_in   = sim_ff;
      id_in    = id_ff;
      ovf_in   = ovf_ff;
      zero_in  = zero_ff;
      case (state_ff)
         css_pkg::B_IDLE: begin
            if (q_pop) begin
               id_in    = q_job.doc_id;
               ovf_in   = q_job.overflow;
               dot_in   = q_job.dot_sum;
               zero_in  = (q_job.query_sum == '0) || (q_job.doc_sum == '0);
               rad_q_in = css_pkg::RAD_W'(q_job.query_sum) << css_pkg::NORM_SHIFT;
               rad_d_in = css_pkg::RAD_W'(q_job.doc_sum) << css_pkg::NORM_SHIFT;
               sq_q_in  = '0;
               sq_d_in  = '0;
               step_in  = '0;
            end
         end
         css_pkg::B_SQRT: begin
            sq_q_in  = css_pkg::sqrt_step(sq_q_ff, rad_q_ff[css_pkg::RAD_W-1 -: 2]);
            sq_d_in  = css_pkg::sqrt_step(sq_d_ff, rad_d_ff[css_pkg::RAD_W-1 -: 2]);
            rad_q_in = rad_q_ff << 2;
            rad_d_in = rad_d_ff << 2;
            step_in  = css_pkg::STEP_W'(step_ff + 1'b1);
         end
         css_pkg::B_MUL: begin
            den_in  = css_pkg::DEN_W'(sq_q_ff.root) * css_pkg::DEN_W'(sq_d_ff.root);
            rem_in  = css_pkg::DEN_W'(dot_ff) << css_pkg::NORM_SHIFT;
            quo_in  = '0;
            step_in = '0;
         end
         css_pkg::B_CHECK: begin
            if (zero_ff) begin
               sim_in = '0;
            end else if (saturate) begin
               sim_in = css_pkg::SIM_ONE;
            end
         end
         css_pkg::B_DIV: begin
            // one quotient bit a cycle, restoring
            if (rem_ge) begin
               rem_in = css_pkg::DEN_W'(rem_shift - {1'b0, den_ff});
            end else begin
               rem_in = rem_shift[css_pkg::DEN_W-1:0];
            end
            quo_in  = quo_next;
            step_in = css_pkg::STEP_W'(step_ff + 1'b1);
            if (div_last) begin
               sim_in = css_pkg::SIM_W'(quo_next);
            end
         end
         default: begin
            step_in = step_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_sim_in   = rsp_sim_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = id_ff;
         rsp_sim_in   = sim_ff;
         rsp_zero_in  = zero_ff;
         rsp_ovf_in   = ovf_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= css_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      rad_q_ff    <= rad_q_in;
      rad_d_ff    <= rad_d_in;
      sq_q_ff     <= sq_q_in;
      sq_d_ff     <= sq_d_in;
      dot_ff      <= dot_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      sim_ff      <= sim_in;
      id_ff       <= id_in;
      ovf_ff      <= ovf_in;
      zero_ff     <= zero_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_sim_ff  <= rsp_sim_in;
      rsp_zero_ff <= rsp_zero_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_score_doc_id  = rsp_id_ff;
   assign rsp_similarity    = rsp_sim_ff;
   assign rsp_zero_norm     = rsp_zero_ff;
   assign rsp_term_overflow = rsp_ovf_ff;

   a_zero_norm_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zero_ff) |-> (rsp_sim_ff == '0))
      else $error("zero norm word with nonzero similarity");

   a_similarity_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sim_ff <= css_pkg::SIM_ONE))
      else $error("similarity above one");

   a_nonzero_norms_give_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == css_pkg::B_CHECK && !zero_ff) |-> (den_ff != '0))
      else $error("zero divisor with both norms nonzero");

endmodule

[hw/rtl/cosine_similarity_scorer_core.sv]
// Channel  Direction  Handshake              Word
// req      in         req_valid/req_ready    doc_id, query/doc weight, last_term
// rsp      out        rsp_valid/rsp_ready    doc id, similarity, zero_norm, overflow
//
// The front takes one term a cycle; a full two-word queue stalls it only on a last term.
// The back scores one document in order: a pop, 32 square root steps
// (both norms side by side, one root bit a cycle), a multiply, a check, 16 divide steps
// and an output load that waits for a free output; a zero norm or a saturated score
// skips the divide. A new document is popped only after the last is loaded out.
// Reset is synchronous and clears the sums, the queue and both handshakes.
module cosine_similarity_scorer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [css_pkg::ID_W-1:0]         req_doc_id,
   input  logic [css_pkg::WEIGHT_W-1:0]     req_query_weight,
   input  logic [css_pkg::WEIGHT_W-1:0]     req_doc_weight,
   input  logic                             req_last_term,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [css_pkg::ID_W-1:0]         rsp_score_doc_id,
   output logic [css_pkg::SIM_W-1:0]        rsp_similarity,
   output logic                             rsp_zero_norm,
   output logic                             rsp_term_overflow
);

   logic                  push_valid;
   css_pkg::css_job_type  push_job;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_empty;
   css_pkg::css_job_type  q_job;

   css_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_doc_id       (req_doc_id),
      .req_query_weight (req_query_weight),
      .req_doc_weight   (req_doc_weight),
      .req_last_term    (req_last_term),
      .q_full           (q_full),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   css_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_job    (q_job)
   );

   css_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_job             (q_job),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_score_doc_id  (rsp_score_doc_id),
      .rsp_similarity    (rsp_similarity),
      .rsp_zero_norm     (rsp_zero_norm),
      .rsp_term_overflow (rsp_term_overflow)
   );

endmodule
